>>> hdl/blist_pkg.sv
`default_nettype none

package blist_pkg;

   // Field widths of the request and response transfers
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned LENGTH_W = 5;
   localparam int unsigned STATUS_W = 2;

   // Operation codes carried in the mode field
   typedef enum logic [MODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // Status codes returned with every response
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> hdl/blist_req_if.sv
`default_nettype none

interface blist_req_if;

   logic                                valid;
   logic                                ready;
   logic [blist_pkg::MODE_W-1:0]        mode;
   logic [blist_pkg::INDEX_W-1:0]       index;
   logic [blist_pkg::VALUE_W-1:0]       value;

   modport source (output valid, output mode, output index, output value, input ready);
   modport sink   (input valid, input mode, input index, input value, output ready);

endinterface

`default_nettype wire

>>> hdl/blist_rsp_if.sv
`default_nettype none

interface blist_rsp_if;

   logic                                valid;
   logic                                ready;
   logic [blist_pkg::VALUE_W-1:0]       read_value;
   logic [blist_pkg::LENGTH_W-1:0]      length;
   logic [blist_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output read_value, output length, output status,
                   input ready);
   modport sink   (input valid, input read_value, input length, input status,
                   output ready);

endinterface

`default_nettype wire

>>> hdl/blist_mem.sv
`default_nettype none

module blist_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   // Register read data; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/blist_ctrl.sv
`default_nettype none

module blist_ctrl #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   blist_req_if.sink                        req_chan,
   blist_rsp_if.source                      rsp_chan,
   output logic                             mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
   output logic [DATA_WIDTH-1:0]            mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
   input  wire logic [DATA_WIDTH-1:0]       mem_rd_data
);

   localparam int unsigned AW    = $clog2(CAPACITY);
   localparam int unsigned CW    = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CW > blist_pkg::INDEX_W) ? CW : blist_pkg::INDEX_W;
   localparam int unsigned EW    = CMP_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SHIFT
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [AW-1:0]                  ptr_ff, ptr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [blist_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [blist_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   blist_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                           accept;
   logic [EW-1:0]                  idx_ext;
   logic [EW-1:0]                  cnt_ext;
   logic [EW-1:0]                  ptr_ext;
   logic [CW-1:0]                  cnt_inc;
   logic [CW-1:0]                  cnt_dec;

   // Take a request only when idle and the output register is free or draining
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign idx_ext = EW'(req_chan.index);
   assign cnt_ext = EW'(cnt_ff);
   assign ptr_ext = EW'(ptr_ff);
   assign cnt_inc = cnt_ff + CW'(1);
   assign cnt_dec = cnt_ff - CW'(1);

   // Sequence each operation and build its response
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cnt_ff[AW-1:0];
      mem_wr_data   = DATA_WIDTH'(req_chan.value);
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ext[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_length_in = blist_pkg::LENGTH_W'(cnt_ff);
               rsp_status_in = blist_pkg::STATUS_OK;
               unique case (blist_pkg::op_type'(req_chan.mode))
                  blist_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ext == EW'(CAPACITY)) begin
                        rsp_status_in = blist_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en     = 1'b1;
                        cnt_in        = cnt_inc;
                        rsp_length_in = blist_pkg::LENGTH_W'(cnt_inc);
                     end
                  end
                  blist_pkg::OP_READ: begin
                     if (idx_ext < cnt_ext) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_READ_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  blist_pkg::OP_REMOVE: begin
                     if (idx_ext >= cnt_ext) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = blist_pkg::STATUS_BAD_INDEX;
                     end else if (idx_ext + EW'(1) < cnt_ext) begin
                        // Fetch the entry above the hole and start shifting
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(idx_ext + EW'(1));
                        ptr_in      = idx_ext[AW-1:0];
                        state_in    = ST_SHIFT;
                     end else begin
                        // Last entry removed: just drop the length
                        rsp_valid_in  = 1'b1;
                        cnt_in        = cnt_dec;
                        rsp_length_in = blist_pkg::LENGTH_W'(cnt_dec);
                     end
                  end
                  blist_pkg::OP_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     cnt_in        = '0;
                     rsp_length_in = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            // Output register drained on the accept edge, so load it now
            rsp_valid_in = 1'b1;
            rsp_value_in = blist_pkg::VALUE_W'(mem_rd_data);
            state_in     = ST_IDLE;
         end
         ST_SHIFT: begin
            // Move one entry down while fetching the next one
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            mem_wr_data = mem_rd_data;
            if (ptr_ext + EW'(2) < cnt_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(ptr_ext + EW'(2));
               ptr_in      = ptr_ff + AW'(1);
            end else begin
               cnt_in        = cnt_dec;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_length_in = blist_pkg::LENGTH_W'(cnt_dec);
               rsp_status_in = blist_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, length and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.length     = rsp_length_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> hdl/bounded_list_append_read_remove_unit.sv
// Bounded ordered list with append, indexed read, remove at index and clear.
// Requests arrive on req_chan (mode, index, value); each gives one response
// on rsp_chan (read_value, length, status), both valid/ready channels where a
// transfer happens on a clock edge with valid and ready high.
// Entries live in a single-port-write, single-port-read memory of CAPACITY
// slots with a registered read; the length sits in a register.
// Each response is registered: append, clear, out-of-range read or remove
// and removal of the last entry answer in the cycle after the request
// transfer; a read in range passes the memory's read register and then
// ST_READ_WAIT; remove at index i with length n, i < n-1, passes ST_SHIFT,
// one entry moved per cycle through the memory's read and write ports.
// One request is in flight at a time; the next is taken in the cycle its
// predecessor's response is transferred, or at once if the output is empty.
// A stalled receiver holds the response in the output register and blocks
// new requests. Synchronous reset empties the list and drops any pending
// response; memory contents are left as they are, since no slot at or above
// the length is ever read.
`default_nettype none

module bounded_list_append_read_remove_unit #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   blist_req_if.sink     req_chan,
   blist_rsp_if.source   rsp_chan
);

   localparam int unsigned AW = $clog2(CAPACITY);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   blist_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   blist_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

>>> tb/sv/blist_checker.sv
`default_nettype none

module blist_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   blist_req_if        req_mon,
   blist_rsp_if        rsp_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);

   import blist_pkg::*;

   localparam int unsigned SLOTS       = 16;
   localparam int unsigned REPORT_MAX  = 10;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [LENGTH_W-1:0] length;
      status_type          status;
   } list_rsp_type;

   // Shadow copy of the list contents and its length
   logic [VALUE_W-1:0]  list_slots [SLOTS];
   logic [LENGTH_W-1:0] list_len;
   list_rsp_type        rsp_expected_q [$];
   int unsigned         fail_tally;

   // Apply one operation to the shadow list and return the response it gives
   function automatic list_rsp_type apply_list_op(op_type op, logic [INDEX_W-1:0] idx,
                                                  logic [VALUE_W-1:0] val);
      list_rsp_type r;
      int unsigned i;
      r.read_value = '0;
      r.status     = STATUS_OK;
      case (op)
         OP_APPEND: begin
            if (list_len >= LENGTH_W'(SLOTS)) begin
               r.status = STATUS_FULL;
            end else begin
               list_slots[list_len[INDEX_W-1:0]] = val;
               list_len = list_len + 1'b1;
            end
         end
         OP_READ: begin
            if (LENGTH_W'(idx) < list_len) r.read_value = list_slots[idx];
         end
         OP_REMOVE: begin
            if (LENGTH_W'(idx) >= list_len) begin
               r.status = STATUS_BAD_INDEX;
            end else begin
               // close the gap and zero the vacated top slot
               for (i = 32'(idx); i + 1 < list_len; i++)
                  list_slots[INDEX_W'(i)] = list_slots[INDEX_W'(i + 1)];
               list_slots[INDEX_W'(list_len - 1'b1)] = '0;
               list_len = list_len - 1'b1;
            end
         end
         default: begin
            for (i = 0; i < SLOTS; i++) list_slots[INDEX_W'(i)] = '0;
            list_len = '0;
         end
      endcase
      r.length = list_len;
      return r;
   endfunction

   // Compare each response transfer with the oldest prediction, then predict
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         rsp_expected_q.delete();
         for (int unsigned k = 0; k < SLOTS; k++) list_slots[INDEX_W'(k)] = '0;
         list_len   = '0;
         fail_tally = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rsp_expected_q.size() == 0) begin
               if (fail_tally < REPORT_MAX)
                  $display("unexpected response: read_value %h length %0d status %0d",
                           rsp_mon.read_value, rsp_mon.length, rsp_mon.status);
               fail_tally++;
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_mon.read_value !== want.read_value || rsp_mon.length !== want.length ||
                   rsp_mon.status !== want.status) begin
                  if (fail_tally < REPORT_MAX)
                     $display("response mismatch: read_value exp %h got %h, ",
                              want.read_value, rsp_mon.read_value,
                              "length exp %0d got %0d, ", want.length, rsp_mon.length,
                              "status exp %0d got %0d", want.status, rsp_mon.status);
                  fail_tally++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            rsp_expected_q.push_back(apply_list_op(op_type'(req_mon.mode), req_mon.index,
                                                   req_mon.value));
      end
      mismatches  <= fail_tally;
      outstanding <= rsp_expected_q.size();
   end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;

   import blist_pkg::*;

   localparam int unsigned SLOTS        = 16;
   localparam int unsigned PHASE_ITEMS  = 300;
   localparam int unsigned GAP_MAX      = 40;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned shadow_len     = 0;

   blist_req_if req_if ();
   blist_rsp_if rsp_if ();

   bounded_list_append_read_remove_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   blist_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   // Stall the receiver at random according to the current phase
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Give up if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb NOT OK");
      $finish;
   end

   // Hand one request over, after a random idle gap; hold valid until the transfer
   task automatic send_op(op_type op, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < GAP_MAX) gap++;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= op;
      req_if.index <= idx;
      req_if.value <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // track the length roughly so that indexes can be aimed in range
      case (op)
         OP_APPEND: if (shadow_len < SLOTS) shadow_len++;
         OP_REMOVE: if (idx < shadow_len) shadow_len--;
         OP_CLEAR:  shadow_len = 0;
         default:   ;
      endcase
   endtask

   // Drop valid and hold off until every response has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Mostly appends, reads and removes at live indexes, with a few clears
   task automatic random_item();
      int unsigned      pick;
      op_type           op;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] val;
      pick = $urandom_range(99);
      if (pick < 42)      op = OP_APPEND;
      else if (pick < 70) op = OP_READ;
      else if (pick < 96) op = OP_REMOVE;
      else                op = OP_CLEAR;
      if (shadow_len != 0 && $urandom_range(99) < 75)
         idx = INDEX_W'($urandom_range(shadow_len - 1));
      else
         idx = INDEX_W'($urandom_range(SLOTS - 1));
      case ($urandom_range(9))
         0:       val = '0;
         1:       val = '1;
         default: val = $urandom();
      endcase
      send_op(op, idx, val);
   endtask

   initial begin
      int unsigned phase_idle [4];
      int unsigned phase_stall [4];
      phase_idle  = '{0, 57, 0, 9};
      phase_stall = '{0, 0, 57, 9};
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.mode  <= OP_APPEND;
      req_if.index <= '0;
      req_if.value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme values, fill to the top, refused append, edge indexes
      send_op(OP_APPEND, 4'd0, 32'h0000_0000);
      send_op(OP_APPEND, 4'd0, 32'hFFFF_FFFF);
      send_op(OP_APPEND, 4'd0, 32'h5555_5555);
      send_op(OP_APPEND, 4'd0, 32'hAAAA_AAAA);
      repeat (SLOTS - 4) send_op(OP_APPEND, 4'd0, $urandom());
      send_op(OP_APPEND, 4'd0, 32'hDEAD_0001);
      send_op(OP_READ,   4'd0,  '0);
      send_op(OP_READ,   4'd15, '0);
      send_op(OP_REMOVE, 4'd15, '0);
      send_op(OP_REMOVE, 4'd0,  '0);
      send_op(OP_REMOVE, 4'd7,  '0);
      send_op(OP_READ,   4'd14, '0);
      send_op(OP_REMOVE, 4'd14, '0);
      send_op(OP_READ,   4'd12, '1);
      send_op(OP_CLEAR,  4'd15, '1);
      send_op(OP_READ,   4'd0,  '0);
      send_op(OP_REMOVE, 4'd0,  '0);
      drain();

      // Random phases with different idling on either side
      for (int unsigned p = 0; p < 4; p++) begin
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            random_item();
            if (n == PHASE_ITEMS / 2 && p == 1) drain();
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hdl/blist_pkg.sv
hdl/blist_req_if.sv
hdl/blist_rsp_if.sv
hdl/blist_mem.sv
hdl/blist_ctrl.sv
hdl/bounded_list_append_read_remove_unit.sv
tb/sv/blist_checker.sv
tb/sv/tb.sv
